@@ sv/pdq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdq_pkg
// Types and constants shared by the positional deque and its storage cells.
// ----------------------------------------------------------------------------
package pdq_pkg;

  // Number of storage cells; the 5-bit count and position fields can hold it.
  localparam int unsigned Capacity = 16;
  localparam int unsigned IdxW     = $clog2(Capacity);
  localparam int unsigned CntW     = 5;

  typedef enum logic [3:0] {
    CMD_PUSH_BACK  = 4'd0,
    CMD_PUSH_FRONT = 4'd1,
    CMD_POP_FRONT  = 4'd2,
    CMD_POP_BACK   = 4'd3,
    CMD_INS_HEAD   = 4'd4,
    CMD_INS_TAIL   = 4'd5,
    CMD_REM_HEAD   = 4'd6,
    CMD_REM_TAIL   = 4'd7,
    CMD_READ_HEAD  = 4'd8,
    CMD_READ_TAIL  = 4'd9
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  typedef struct packed {
    logic [31:0] cell_word;
    logic [31:0] link;
  } entry_t;

  typedef struct packed {
    logic [3:0]      cmd;
    logic [CntW-1:0] position;
    logic [31:0]     cell_value;
    logic [31:0]     link_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]      status;
    logic [31:0]     entry_cell;
    logic [31:0]     entry_link;
    logic [CntW-1:0] fill_count;
  } out_item_t;

  // Shift control broadcast to every cell.
  typedef struct packed {
    logic            ins;
    logic            rem;
    logic [CntW-1:0] idx;
  } cell_ctrl_t;

endpackage

@@ sv/pdq_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdq_cell
// One storage slot; takes the new entry on an insert at its place, shifts to
// the tail on an insert ahead of it, to the head on a removal at or ahead.
// ----------------------------------------------------------------------------
module pdq_cell #(
  parameter int unsigned CellIdx = 0
) (
  input  logic               clk_i,
  input  pdq_pkg::cell_ctrl_t ctrl_i,
  input  pdq_pkg::entry_t    new_i,
  input  pdq_pkg::entry_t    left_i,
  input  pdq_pkg::entry_t    right_i,
  output pdq_pkg::entry_t    data_o
);

  localparam logic [pdq_pkg::CntW-1:0] MyIdx = pdq_pkg::CntW'(CellIdx);

  pdq_pkg::entry_t data_q, data_d;

  always_comb begin
    data_d = data_q;
    if (ctrl_i.ins) begin
      if (MyIdx == ctrl_i.idx) begin
        data_d = new_i;
      end else if (MyIdx > ctrl_i.idx) begin
        data_d = left_i;
      end
    end else if (ctrl_i.rem && (MyIdx >= ctrl_i.idx)) begin
      data_d = right_i;
    end
  end

  // Payload only: slots beyond the fill count are never read.
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

@@ sv/positional_deque.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_deque
// Bounded double-ended queue with positional insert, remove and read.
// ----------------------------------------------------------------------------
// Commands arrive on the in channel (valid/ready); each item gives exactly one
// result on the out channel: a status, the entry concerned and the fill count.
// Entries live in a row of cells with the head in cell 0. An insert or a
// removal shifts every cell behind the chosen position by one place in the
// same clock. The result is registered; out_valid_o rises in the cycle after
// acceptance. Throughput is one item per cycle while the receiver takes each
// result: the result register is reloaded in the cycle it is drained.
// When the receiver stalls, the result is held and in_ready_o drops until the
// result is taken; nothing is lost.
// The cfg channel writes the length limit (0 means all cells); it is always
// ready and should only be written while no command is outstanding.
// Reset clears the fill count, the limit and the result valid flag; cell
// contents are left as they are and need no clearing.
// ----------------------------------------------------------------------------
module positional_deque (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  pdq_pkg::in_item_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output pdq_pkg::out_item_t  out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [pdq_pkg::CntW-1:0] cfg_data_i
);

  localparam int unsigned CntW = pdq_pkg::CntW;
  localparam int unsigned IdxW = pdq_pkg::IdxW;
  localparam logic [CntW-1:0] CapCnt = CntW'(pdq_pkg::Capacity);

  logic [CntW-1:0]    cnt_q, cnt_d, lim_q, eff_lim;
  logic               out_valid_q;
  pdq_pkg::out_item_t out_q, out_d;
  logic               fire, full, empty;
  pdq_pkg::cell_ctrl_t ctrl;
  pdq_pkg::entry_t    new_entry;
  pdq_pkg::entry_t    cell_data [pdq_pkg::Capacity];
  pdq_pkg::status_e   st;
  logic               is_ins, is_take, is_rem, bad_pos;
  logic [CntW-1:0]    idx;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign fire        = in_valid_i && in_ready_o;

  assign eff_lim = ((lim_q == '0) || (lim_q > CapCnt)) ? CapCnt : lim_q;
  assign full    = cnt_q >= eff_lim;
  assign empty   = cnt_q == '0;

  assign new_entry.cell_word = in_data_i.cell_value;
  assign new_entry.link      = in_data_i.link_value;

  always_comb begin
    is_ins  = 1'b0;
    is_take = 1'b0;
    is_rem  = 1'b0;
    bad_pos = 1'b0;
    idx     = '0;
    unique case (pdq_pkg::cmd_e'(in_data_i.cmd))
      pdq_pkg::CMD_PUSH_BACK: begin
        is_ins = 1'b1;
        idx    = cnt_q;
      end
      pdq_pkg::CMD_PUSH_FRONT: begin
        is_ins = 1'b1;
      end
      pdq_pkg::CMD_POP_FRONT: begin
        is_take = 1'b1;
        is_rem  = 1'b1;
      end
      pdq_pkg::CMD_POP_BACK: begin
        is_take = 1'b1;
        is_rem  = 1'b1;
        idx     = cnt_q - CntW'(1);
      end
      pdq_pkg::CMD_INS_HEAD: begin
        is_ins  = 1'b1;
        bad_pos = in_data_i.position > cnt_q;
        idx     = in_data_i.position;
      end
      pdq_pkg::CMD_INS_TAIL: begin
        is_ins  = 1'b1;
        bad_pos = in_data_i.position > cnt_q;
        idx     = cnt_q - in_data_i.position;
      end
      pdq_pkg::CMD_REM_HEAD, pdq_pkg::CMD_READ_HEAD: begin
        is_take = 1'b1;
        is_rem  = in_data_i.cmd == pdq_pkg::CMD_REM_HEAD;
        bad_pos = in_data_i.position >= cnt_q;
        idx     = in_data_i.position;
      end
      pdq_pkg::CMD_REM_TAIL, pdq_pkg::CMD_READ_TAIL: begin
        is_take = 1'b1;
        is_rem  = in_data_i.cmd == pdq_pkg::CMD_REM_TAIL;
        bad_pos = in_data_i.position >= cnt_q;
        idx     = cnt_q - CntW'(1) - in_data_i.position;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    st = pdq_pkg::ST_OK;
    if (is_ins) begin
      if (full) begin
        st = pdq_pkg::ST_FULL;
      end else if (bad_pos) begin
        st = pdq_pkg::ST_RANGE;
      end
    end else if (is_take) begin
      if (empty) begin
        st = pdq_pkg::ST_EMPTY;
      end else if (bad_pos) begin
        st = pdq_pkg::ST_RANGE;
      end
    end

    ctrl.ins = fire && is_ins && (st == pdq_pkg::ST_OK);
    ctrl.rem = fire && is_rem && (st == pdq_pkg::ST_OK);
    ctrl.idx = idx;

    cnt_d = cnt_q;
    if (ctrl.ins) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (ctrl.rem) begin
      cnt_d = cnt_q - CntW'(1);
    end

    out_d.status     = st;
    out_d.entry_cell = '0;
    out_d.entry_link = '0;
    out_d.fill_count = cnt_d;
    // A successful take has idx below the count, so the low bits address it.
    if (is_take && (st == pdq_pkg::ST_OK)) begin
      out_d.entry_cell = cell_data[idx[IdxW-1:0]].cell_word;
      out_d.entry_link = cell_data[idx[IdxW-1:0]].link;
    end
  end

  for (genvar k = 0; k < pdq_pkg::Capacity; k++) begin : g_cell
    pdq_cell #(
      .CellIdx(k)
    ) u_cell (
      .clk_i  (clk_i),
      .ctrl_i (ctrl),
      .new_i  (new_entry),
      .left_i (cell_data[(k == 0) ? 0 : k - 1]),
      .right_i(cell_data[(k == pdq_pkg::Capacity - 1) ? k : k + 1]),
      .data_o (cell_data[k])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      lim_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (cfg_valid_i) begin
        lim_q <= cfg_data_i;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the positional deque against its own queue-based prediction.
// ----------------------------------------------------------------------------
// A short table of directed commands comes first: empty and full answers,
// out-of-range positions, unused codes and a limit below the fill count.
// Random phases follow, each under its own length limit. Every phase drains
// and then refills the queue. Both channels idle and stall at random, and
// two phases run without idling. Every result is compared, field by field,
// with the oldest expected result.
// ----------------------------------------------------------------------------
module testbench;
  import pdq_pkg::*;

  // Command codes that the block ignores.
  localparam int unsigned FirstUnusedCmd = 10;
  localparam int unsigned LastUnusedCmd  = 15;

  typedef struct {
    bit              cfg_write;
    logic [CntW-1:0] limit;
    in_item_t        item;
    bit              typed;
    out_item_t       want;
  } plan_row_t;

  logic            clk          = 1'b0;
  logic            rst_ni       = 1'b0;
  logic            in_valid     = 1'b0;
  in_item_t        in_data      = '0;
  bit              in_typed     = 1'b0;
  out_item_t       in_typed_exp = '0;
  logic            out_ready    = 1'b0;
  logic            cfg_valid    = 1'b0;
  logic [CntW-1:0] cfg_data     = '0;
  logic            in_ready_o;
  logic            out_valid_o;
  out_item_t       out_data_o;
  logic            cfg_ready_o;

  entry_t          shadow_entries[$];
  logic [CntW-1:0] shadow_limit = '0;
  out_item_t       pending_results[$];
  plan_row_t       directed_plan[$];
  int unsigned     failures = 0;
  bit              steady   = 1'b0;

  positional_deque dut (
    .clk_i       (clk),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Applies one command to the shadow queue and returns the answer it gives.
  function automatic out_item_t predict_deque(in_item_t it);
    out_item_t   r;
    entry_t      e;
    int unsigned cnt;
    int unsigned cap;
    int unsigned pos;
    int unsigned idx;
    bit          grows;
    bit          takes;
    bit          keeps;
    cnt   = shadow_entries.size();
    cap   = (shadow_limit == 0 || shadow_limit > Capacity) ? Capacity : shadow_limit;
    pos   = it.position;
    idx   = 0;
    grows = 1'b0;
    takes = 1'b0;
    keeps = 1'b0;
    case (it.cmd)
      CMD_PUSH_BACK: begin
        grows = 1'b1;
        idx   = cnt;
      end
      CMD_PUSH_FRONT: begin
        grows = 1'b1;
      end
      CMD_INS_HEAD: begin
        grows = 1'b1;
        idx   = pos;
      end
      CMD_INS_TAIL: begin
        grows = 1'b1;
        idx   = (pos <= cnt) ? cnt - pos : 32'hFFFF_FFFF;
      end
      CMD_POP_FRONT: begin
        takes = 1'b1;
      end
      CMD_POP_BACK: begin
        takes = 1'b1;
        idx   = (cnt == 0) ? 0 : cnt - 1;
      end
      CMD_REM_HEAD: begin
        takes = 1'b1;
        idx   = pos;
      end
      CMD_REM_TAIL: begin
        takes = 1'b1;
        idx   = (pos < cnt) ? cnt - 1 - pos : 32'hFFFF_FFFF;
      end
      CMD_READ_HEAD: begin
        takes = 1'b1;
        keeps = 1'b1;
        idx   = pos;
      end
      CMD_READ_TAIL: begin
        takes = 1'b1;
        keeps = 1'b1;
        idx   = (pos < cnt) ? cnt - 1 - pos : 32'hFFFF_FFFF;
      end
      default: ;
    endcase
    r           = '0;
    r.status    = ST_OK;
    e.cell_word = it.cell_value;
    e.link      = it.link_value;
    // The full and empty checks take precedence over the position check.
    if (grows) begin
      if (cnt >= cap) r.status = ST_FULL;
      else if (idx > cnt) r.status = ST_RANGE;
      else shadow_entries.insert(idx, e);
    end else if (takes) begin
      if (cnt == 0) r.status = ST_EMPTY;
      else if (idx >= cnt) r.status = ST_RANGE;
      else begin
        e            = shadow_entries[idx];
        r.entry_cell = e.cell_word;
        r.entry_link = e.link;
        if (!keeps) shadow_entries.delete(idx);
      end
    end
    r.fill_count = CntW'(shadow_entries.size());
    return r;
  endfunction

  function automatic int unsigned draw_gap();
    return steady ? 0 : $urandom_range(0, 4);
  endfunction

  // grow_pct sets the share of pushes and inserts among the valid commands.
  function automatic in_item_t random_command(int unsigned cnt, int unsigned grow_pct);
    in_item_t    it;
    int unsigned r;
    bit          grow;
    it.cell_value = $urandom();
    it.link_value = $urandom();
    grow          = 1'b0;
    r             = $urandom_range(0, 99);
    if (r < 3) begin
      it.cmd = 4'($urandom_range(FirstUnusedCmd, LastUnusedCmd));
    end else begin
      r = $urandom_range(0, 99);
      if (r < grow_pct) begin
        grow = 1'b1;
        case ($urandom_range(0, 3))
          0: it.cmd = CMD_PUSH_BACK;
          1: it.cmd = CMD_PUSH_FRONT;
          2: it.cmd = CMD_INS_HEAD;
          default: it.cmd = CMD_INS_TAIL;
        endcase
      end else if (r < grow_pct + (100 - grow_pct) / 3) begin
        it.cmd = $urandom_range(0, 1) ? CMD_READ_HEAD : CMD_READ_TAIL;
      end else begin
        case ($urandom_range(0, 3))
          0: it.cmd = CMD_POP_FRONT;
          1: it.cmd = CMD_POP_BACK;
          2: it.cmd = CMD_REM_HEAD;
          default: it.cmd = CMD_REM_TAIL;
        endcase
      end
    end
    // Mostly positions that are legal for the current fill, now and then any.
    if ($urandom_range(0, 9) == 0) it.position = 5'($urandom_range(0, 31));
    else if (grow) it.position = 5'($urandom_range(0, cnt));
    else it.position = (cnt == 0) ? '0 : 5'($urandom_range(0, cnt - 1));
    return it;
  endfunction

  function automatic void add_cmd(logic [3:0] cmd, logic [CntW-1:0] pos,
                                  logic [31:0] cell_word, logic [31:0] link);
    plan_row_t row;
    row                 = '{default: '0};
    row.item.cmd        = cmd;
    row.item.position   = pos;
    row.item.cell_value = cell_word;
    row.item.link_value = link;
    directed_plan.push_back(row);
  endfunction

  // Rows whose answer carries no entry, so the expected item is typed in.
  function automatic void add_chk(logic [3:0] cmd, logic [CntW-1:0] pos,
                                  logic [31:0] cell_word, logic [31:0] link,
                                  status_e st, logic [CntW-1:0] fill);
    add_cmd(cmd, pos, cell_word, link);
    directed_plan[$].typed           = 1'b1;
    directed_plan[$].want.status     = st;
    directed_plan[$].want.fill_count = fill;
  endfunction

  function automatic void add_lim(logic [CntW-1:0] lim);
    plan_row_t row;
    row           = '{default: '0};
    row.cfg_write = 1'b1;
    row.limit     = lim;
    directed_plan.push_back(row);
  endfunction

  task automatic send_item(in_item_t it, bit typed, out_item_t want);
    int unsigned gap;
    gap = draw_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_data      <= it;
    in_typed     <= typed;
    in_typed_exp <= want;
    @(posedge clk);
    while (!in_ready_o) @(posedge clk);
  endtask

  // Stops sending and waits until every outstanding result has been taken.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_limit(logic [CntW-1:0] lim);
    settle();
    cfg_valid <= 1'b1;
    cfg_data  <= lim;
    @(posedge clk);
    while (!cfg_ready_o) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Receiver: outside the steady phases, stalls for a random number of cycles before each item.
  initial begin
    int unsigned stall;
    forever begin
      stall = draw_gap();
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!(out_valid_o && out_ready)) @(posedge clk);
    end
  end

  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready) begin
        if (pending_results.size() == 0) begin
          failures++;
          if (failures <= 10) $display("unexpected result: %p", out_data_o);
        end else begin
          want = pending_results.pop_front();
          if (out_data_o.status !== want.status || out_data_o.entry_cell !== want.entry_cell ||
              out_data_o.entry_link !== want.entry_link ||
              out_data_o.fill_count !== want.fill_count) begin
            failures++;
            if (failures <= 10)
              $display("mismatch: status %0d/%0d cell %h/%h link %h/%h fill %0d/%0d",
                       want.status, out_data_o.status, want.entry_cell, out_data_o.entry_cell,
                       want.entry_link, out_data_o.entry_link, want.fill_count,
                       out_data_o.fill_count);
          end
        end
      end
      if (cfg_valid && cfg_ready_o) shadow_limit = cfg_data;
      if (in_valid && in_ready_o) begin
        want = predict_deque(in_data);
        pending_results.push_back(in_typed ? in_typed_exp : want);
      end
    end
  end

  initial begin
    logic [CntW-1:0] phase_limits[9];
    int unsigned     grow_pct;
    phase_limits = '{5'd0, 5'd16, 5'd31, 5'd1, 5'd5, 5'd17, 5'd9, 5'd2, 5'd0};

    // Empty answers come before any position check; then pushes and an insert out of range.
    add_chk(CMD_POP_FRONT, 0, 32'h0, 32'h0, ST_EMPTY, 0);
    add_chk(CMD_READ_TAIL, 0, 32'h0, 32'h0, ST_EMPTY, 0);
    add_chk(CMD_REM_HEAD, 31, 32'hFFFF_FFFF, 32'hFFFF_FFFF, ST_EMPTY, 0);
    add_chk(CMD_PUSH_BACK, 0, 32'hFFFF_FFFF, 32'h0, ST_OK, 1);
    add_chk(CMD_PUSH_FRONT, 0, 32'h0, 32'hFFFF_FFFF, ST_OK, 2);
    add_chk(CMD_INS_HEAD, 3, 32'h1234_5678, 32'h9ABC_DEF0, ST_RANGE, 2);
    // Inserts at the far end, from the tail and right at the head; then reads, removals and unused codes.
    add_cmd(CMD_INS_HEAD, 2, 32'h1111_1111, 32'h2222_2222);
    add_cmd(CMD_INS_TAIL, 0, 32'h3333_3333, 32'h4444_4444);
    add_cmd(CMD_INS_TAIL, 4, 32'h5555_5555, 32'h6666_6666);
    add_chk(CMD_READ_HEAD, 5, 32'h0, 32'h0, ST_RANGE, 5);
    add_cmd(CMD_READ_TAIL, 0, 32'h0, 32'h0);
    add_cmd(CMD_READ_HEAD, 2, 32'h0, 32'h0);
    add_cmd(CMD_REM_TAIL, 1, 32'h0, 32'h0);
    add_cmd(CMD_REM_HEAD, 1, 32'h0, 32'h0);
    add_cmd(CMD_POP_BACK, 0, 32'h0, 32'h0);
    add_chk(4'(FirstUnusedCmd), 0, 32'h0, 32'h0, ST_OK, 2);
    add_chk(4'(LastUnusedCmd), 31, 32'hFFFF_FFFF, 32'hFFFF_FFFF, ST_OK, 2);
    add_chk(CMD_INS_HEAD, 31, 32'h0, 32'h0, ST_RANGE, 2);
    // A full queue answers full even when the position is out of range too.
    add_lim(3);
    add_chk(CMD_PUSH_BACK, 0, 32'hA5A5_A5A5, 32'h5A5A_5A5A, ST_OK, 3);
    add_chk(CMD_PUSH_FRONT, 0, 32'h0, 32'h0, ST_FULL, 3);
    add_chk(CMD_INS_TAIL, 31, 32'h0, 32'h0, ST_FULL, 3);
    // A limit below the fill count keeps the entries; removals still work.
    add_lim(1);
    add_chk(CMD_PUSH_BACK, 0, 32'h0, 32'h0, ST_FULL, 3);
    add_cmd(CMD_REM_TAIL, 0, 32'h0, 32'h0);
    add_cmd(CMD_POP_FRONT, 0, 32'h0, 32'h0);
    add_cmd(CMD_READ_TAIL, 0, 32'h0, 32'h0);

    repeat (3) @(posedge clk);
    rst_ni <= 1'b1;

    foreach (directed_plan[i]) begin
      if (directed_plan[i].cfg_write) write_limit(directed_plan[i].limit);
      else send_item(directed_plan[i].item, directed_plan[i].typed, directed_plan[i].want);
    end

    // Each phase first drains, then refills, so the next limit often lands
    // below the fill count.
    for (int p = 0; p < 9; p++) begin
      write_limit(phase_limits[p]);
      steady = (p == 2 || p == 6);
      for (int i = 0; i < 190; i++) begin
        if (p == 4 && i == 95) settle();
        grow_pct = (i < 95) ? 30 : 70;
        send_item(random_command(shadow_entries.size(), grow_pct), 1'b0, '0);
      end
    end
    steady = 1'b0;
    settle();

    if (failures == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("testbench: done, errors");
    $finish;
  end

endmodule

@@ sim.f @@
sv/pdq_pkg.sv
sv/pdq_cell.sv
sv/positional_deque.sv
tb/testbench.sv
